### hw/rtl/first_fit_contiguous_allocator_macros.svh
// Assertion macros for the first-fit allocator.
// Expects clk and rst in the scope where a macro is used.
`ifndef FIRST_FIT_CONTIGUOUS_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_CONTIGUOUS_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FFCA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFCA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ffca_pkg.sv
// Shared constants and control types for the first-fit allocator.
// No dependencies.
package ffca_pkg;

  localparam int MEM_WORDS = 64;
  localparam int IDX_W     = $clog2(MEM_WORDS);
  localparam int CNT_W     = $clog2(MEM_WORDS + 1);
  localparam int SIZE_W    = 7;
  localparam int ADDR_W    = 6;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic shift;
    logic write;
    logic value;
  } map_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic used;
  } scan_ctrl_t;

endpackage

### hw/rtl/ffca_if.sv
// Request and response channel interfaces for the first-fit allocator.
// Depends on ffca_pkg.
interface ffca_req_if;
  import ffca_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [SIZE_W-1:0] block_size;
  logic [ADDR_W-1:0] first_word;
  logic [ADDR_W-1:0] last_word;

  modport source (output valid, op, block_size, first_word, last_word, input ready);
  modport sink (input valid, op, block_size, first_word, last_word, output ready);
endinterface

interface ffca_rsp_if;
  import ffca_pkg::*;
  logic              valid;
  logic              ready;
  logic              success;
  logic [ADDR_W-1:0] block_start;
  logic [ADDR_W-1:0] block_end;

  modport source (output valid, success, block_start, block_end, input ready);
  modport sink (input valid, success, block_start, block_end, output ready);
endinterface

### hw/rtl/ffca_map.sv
// Occupancy map held as a rotating shift register, one word bit per cycle while shift is set.
// Depends on ffca_pkg.
module ffca_map (
  input  logic                clk,
  input  logic                rst,
  input  ffca_pkg::map_ctrl_t ctrl,
  output logic                head
);
  import ffca_pkg::*;

  logic [MEM_WORDS-1:0] map;
  logic                 in_bit;

  assign in_bit = ctrl.write ? ctrl.value : map[0];
  assign head   = map[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      map <= '0;
    end else if (ctrl.shift) begin
      map <= {in_bit, map[MEM_WORDS-1:1]};
    end
  end
endmodule

### hw/rtl/ffca_scan.sv
// Free-run counter that finds the first run of the requested length.
// Depends on ffca_pkg.
module ffca_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  ffca_pkg::scan_ctrl_t ctrl,
  input  logic [ffca_pkg::IDX_W-1:0]  idx,
  input  logic [ffca_pkg::SIZE_W-1:0] size,
  output logic                 found,
  output logic [ffca_pkg::IDX_W-1:0]  start_idx,
  output logic [ffca_pkg::IDX_W-1:0]  end_idx
);
  import ffca_pkg::*;

  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] run_inc;
  logic             hit;

  assign run_inc = run + CNT_W'(1);
  assign hit     = !ctrl.used && (32'(run_inc) == 32'(size));

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= '0;
      found <= 1'b0;
    end else if (ctrl.clear) begin
      run   <= '0;
      found <= 1'b0;
    end else if (ctrl.step && !found) begin
      run <= ctrl.used ? '0 : run_inc;
      if (hit) begin
        found     <= 1'b1;
        end_idx   <= idx;
        start_idx <= idx - IDX_W'(size - SIZE_W'(1));
      end
    end
  end
endmodule

### hw/rtl/first_fit_contiguous_allocator.sv
// First-fit contiguous allocator over a 64-word occupancy map.
// Allocate: scan pass, check, then mark pass (skipped when no run fits); free: mark
// pass only; a rejected request goes straight to response. One request at a time.
// Each pass walks the map one bit per cycle; a second result waits while one is held.
// Synchronous active-high reset: map all free, no response pending.
// Depends on ffca_pkg, ffca_if, ffca_map, ffca_scan and the macros header.
module first_fit_contiguous_allocator (
  input logic        clk,
  input logic        rst,
  ffca_req_if.sink   req,
  ffca_rsp_if.source rsp
);
  import ffca_pkg::*;
  `include "first_fit_contiguous_allocator_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]        state;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic              mark_val;
  logic [SIZE_W-1:0] size_q;
  logic              res_success;
  logic [ADDR_W-1:0] res_start;
  logic [ADDR_W-1:0] res_end;
  logic              rsp_valid;
  logic              rsp_success;
  logic [ADDR_W-1:0] rsp_start;
  logic [ADDR_W-1:0] rsp_end;
  logic              last_pos;
  logic              head;
  logic              found;
  logic [IDX_W-1:0]  found_start;
  logic [IDX_W-1:0]  found_end;
  map_ctrl_t         map_ctrl;
  scan_ctrl_t        scan_ctrl;

  assign last_pos = (pos == IDX_W'(MEM_WORDS - 1));

  always_comb begin
    map_ctrl.shift  = (state == S_SCAN) || (state == S_MARK);
    map_ctrl.write  = (state == S_MARK) && (pos >= lo) && (pos <= hi);
    map_ctrl.value  = mark_val;
    scan_ctrl.clear = (state == S_IDLE);
    scan_ctrl.step  = (state == S_SCAN);
    scan_ctrl.used  = head;
  end

  ffca_map u_map (
    .clk  (clk),
    .rst  (rst),
    .ctrl (map_ctrl),
    .head (head)
  );

  ffca_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (scan_ctrl),
    .idx       (pos),
    .size      (size_q),
    .found     (found),
    .start_idx (found_start),
    .end_idx   (found_end)
  );

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.success     = rsp_success;
  assign rsp.block_start = rsp_start;
  assign rsp.block_end   = rsp_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp.ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            size_q    <= req.block_size;
            pos       <= '0;
            res_start <= '0;
            res_end   <= '0;
            if (req.op == OP_ALLOC) begin
              if (req.block_size == '0 || 32'(req.block_size) > MEM_WORDS) begin
                res_success <= 1'b0;
                state       <= S_RESP;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              if (req.first_word > req.last_word || 32'(req.last_word) >= MEM_WORDS) begin
                res_success <= 1'b0;
                state       <= S_RESP;
              end else begin
                lo          <= IDX_W'(req.first_word);
                hi          <= IDX_W'(req.last_word);
                mark_val    <= 1'b0;
                res_success <= 1'b1;
                state       <= S_MARK;
              end
            end
          end
        end
        S_SCAN: begin
          pos <= last_pos ? '0 : pos + IDX_W'(1);
          if (last_pos) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (found) begin
            lo          <= found_start;
            hi          <= found_end;
            mark_val    <= 1'b1;
            res_success <= 1'b1;
            res_start   <= ADDR_W'(found_start);
            res_end     <= ADDR_W'(found_end);
            state       <= S_MARK;
          end else begin
            res_success <= 1'b0;
            state       <= S_RESP;
          end
        end
        S_MARK: begin
          pos <= last_pos ? '0 : pos + IDX_W'(1);
          if (last_pos) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            rsp_success <= res_success;
            rsp_start   <= res_start;
            rsp_end     <= res_end;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFCA_ASSERT_IMP(a_fail_zero, rsp_valid && !rsp_success, ~|{rsp_start, rsp_end}, "failed with a block")
  `FFCA_ASSERT_IMP(a_block_order, rsp_valid && rsp_success, rsp_end >= rsp_start, "reversed block")
  `FFCA_ASSERT_NXT(a_mark_exit, state == S_MARK, state == S_MARK || state == S_RESP, "bad mark exit")
  `FFCA_ASSERT_NXT(a_scan_step, state == S_SCAN && !last_pos, pos == $past(pos) + IDX_W'(1), "skip")

endmodule
